// File: src/pfpu_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// pfpu_pkg
// Shared types, constants and saturating Q16.16 arithmetic for the phase
// field point update pipeline.
// ============================================================================
package pfpu_pkg;

    localparam int W         = 32;
    localparam int FRAC      = 16;
    localparam int CFG_IDX_W = 3;
    localparam int NSTAGE    = 11;

    typedef logic signed [W-1:0] word_t;

    localparam word_t WMAX  = {1'b0, {(W-1){1'b1}}};
    localparam word_t WMIN  = {1'b1, {(W-1){1'b0}}};
    localparam word_t WZERO = '0;
    // 1.0 clipped to the word range on narrow words
    localparam word_t ONE   = (W > FRAC + 1) ? word_t'(64'sd1 <<< FRAC) : WMAX;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_GAIN      = 3'd0,
        REG_KAPPA_GAIN     = 3'd1,
        REG_ALPHA_GAIN     = 3'd2,
        REG_PHASE_LEVEL    = 3'd3,
        REG_MOTILITY_GAIN  = 3'd4,
        REG_VOLUME_GAIN    = 3'd5,
        REG_VOLUME_SCALE   = 3'd6,
        REG_EXCLUSION_GAIN = 3'd7
    } cfg_idx_t;

    localparam word_t RST_STEP_GAIN      = word_t'(655);
    localparam word_t RST_KAPPA_GAIN     = word_t'(0);
    localparam word_t RST_ALPHA_GAIN     = word_t'(0);
    localparam word_t RST_PHASE_LEVEL    = (W > FRAC + 1) ? word_t'(65536) : WMAX;
    localparam word_t RST_MOTILITY_GAIN  = word_t'(0);
    localparam word_t RST_VOLUME_GAIN    = word_t'(0);
    localparam word_t RST_VOLUME_SCALE   = word_t'(20861);
    localparam word_t RST_EXCLUSION_GAIN = word_t'(0);

    typedef struct packed {
        word_t step_gain;
        word_t kappa_gain;
        word_t alpha_gain;
        word_t phase_level;
        word_t motility_gain;
        word_t volume_gain;
        word_t volume_scale;
        word_t exclusion_gain;
    } cfg_t;

    typedef struct packed {
        logic [NSTAGE-1:0] en;
        logic              out_valid;
    } pipe_ctl_t;

    typedef struct packed {
        logic  ovf;
        word_t val;
    } sres_t;

    function automatic sres_t sat_add(word_t a, word_t b);
        logic [W:0] s;
        sres_t      r;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1])
        begin
            r.ovf = 1'b1;
            r.val = s[W] ? WMIN : WMAX;
        end
        else
        begin
            r.ovf = 1'b0;
            r.val = s[W-1:0];
        end
        return r;
    endfunction

    function automatic sres_t sat_sub(word_t a, word_t b);
        logic [W:0] s;
        sres_t      r;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1])
        begin
            r.ovf = 1'b1;
            r.val = s[W] ? WMIN : WMAX;
        end
        else
        begin
            r.ovf = 1'b0;
            r.val = s[W-1:0];
        end
        return r;
    endfunction

    // product floored by FRAC bits, clipped to the word range
    function automatic sres_t sat_mul(word_t a, word_t b);
        logic signed [2*W-1:0]    p;
        logic [2*W-1:W-1+FRAC]    top;
        sres_t                    r;
        p   = a * b;
        top = p[2*W-1:W-1+FRAC];
        if ((&top) || !(|top))
        begin
            r.ovf = 1'b0;
            r.val = p[W-1+FRAC:FRAC];
        end
        else
        begin
            r.ovf = 1'b1;
            r.val = p[2*W-1] ? WMIN : WMAX;
        end
        return r;
    endfunction

    // floor division by two
    function automatic word_t half(word_t a);
        return a >>> 1;
    endfunction

endpackage

// File: src/pfpu_cfg_regs.sv
`timescale 1ns / 1ps
// ============================================================================
// pfpu_cfg_regs
// Configuration register bank, written one word at a time over the
// configuration channel.
// ============================================================================
module pfpu_cfg_regs
    import pfpu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [W-1:0]         cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_STEP_GAIN:      cfg_next.step_gain      = cfg_data;
                REG_KAPPA_GAIN:     cfg_next.kappa_gain     = cfg_data;
                REG_ALPHA_GAIN:     cfg_next.alpha_gain     = cfg_data;
                REG_PHASE_LEVEL:    cfg_next.phase_level    = cfg_data;
                REG_MOTILITY_GAIN:  cfg_next.motility_gain  = cfg_data;
                REG_VOLUME_GAIN:    cfg_next.volume_gain    = cfg_data;
                REG_VOLUME_SCALE:   cfg_next.volume_scale   = cfg_data;
                REG_EXCLUSION_GAIN: cfg_next.exclusion_gain = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_gain      <= RST_STEP_GAIN;
            cfg_reg.kappa_gain     <= RST_KAPPA_GAIN;
            cfg_reg.alpha_gain     <= RST_ALPHA_GAIN;
            cfg_reg.phase_level    <= RST_PHASE_LEVEL;
            cfg_reg.motility_gain  <= RST_MOTILITY_GAIN;
            cfg_reg.volume_gain    <= RST_VOLUME_GAIN;
            cfg_reg.volume_scale   <= RST_VOLUME_SCALE;
            cfg_reg.exclusion_gain <= RST_EXCLUSION_GAIN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: src/pfpu_pipe_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// pfpu_pipe_ctrl
// Valid bits and per-stage advance enables; a stage moves on when it is
// empty or the stage after it moves, so bubbles close up under a stall.
// ============================================================================
module pfpu_pipe_ctrl
    import pfpu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pt_valid,
    output logic      pt_stall,
    input  logic      res_stall,
    output pipe_ctl_t ctl
);

    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] vld_next;
    logic [NSTAGE-1:0] en;
    logic [NSTAGE-1:0] vld_src;

    always_comb
    begin
        en[NSTAGE-1] = !vld_reg[NSTAGE-1] || !res_stall;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign vld_src = {vld_reg[NSTAGE-2:0], pt_valid};

    always_comb
    begin
        for (int k = 0; k < NSTAGE; k++)
        begin
            vld_next[k] = en[k] ? vld_src[k] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign pt_stall      = !en[0];
    assign ctl.en        = en;
    assign ctl.out_valid = vld_reg[NSTAGE-1];

endmodule

// File: src/pfpu_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// pfpu_datapath
// Eleven-stage saturating Q16.16 datapath: one multiply or one add per
// stage on each path, with the clip flag carried alongside.
// ============================================================================
module pfpu_datapath
    import pfpu_pkg::*;
(
    input  logic              clk,
    input  logic [NSTAGE-1:0] en,
    input  cfg_t              cfg,
    input  word_t             phi_center,
    input  word_t             phi_east,
    input  word_t             phi_west,
    input  word_t             phi_north,
    input  word_t             phi_south,
    input  word_t             cell_volume,
    input  word_t             vel_x,
    input  word_t             vel_y,
    input  word_t             overlap_sum,
    output word_t             phi_new,
    output logic              saturated
);

    // ---- stage 1: first sums, differences and products of raw inputs
    sres_t a_t1, a_c2, a_gxd, a_gyd, a_pm, a_chh, a_nmot, a_dmu, a_deps;
    sres_t a_ac, a_vsv, a_cc;

    word_t s1_c_reg, s1_n_reg, s1_s_reg, s1_ov_reg, s1_vx_reg, s1_vy_reg;
    word_t s1_t1_reg, s1_c2_reg, s1_gxd_reg, s1_gyd_reg, s1_pm_reg, s1_chh_reg;
    word_t s1_nmot_reg, s1_dmu_reg, s1_deps_reg, s1_ac_reg, s1_vsv_reg, s1_cc_reg;
    logic  s1_flag_reg;

    always_comb
    begin
        a_t1   = sat_add(phi_east, phi_west);
        a_c2   = sat_add(phi_center, phi_center);
        a_gxd  = sat_sub(phi_east, phi_west);
        a_gyd  = sat_sub(phi_north, phi_south);
        a_pm   = sat_sub(cfg.phase_level, phi_center);
        a_chh  = sat_sub(phi_center, half(cfg.phase_level));
        a_nmot = sat_sub(WZERO, cfg.motility_gain);
        a_dmu  = sat_add(cfg.volume_gain, cfg.volume_gain);
        a_deps = sat_add(cfg.exclusion_gain, cfg.exclusion_gain);
        a_ac   = sat_mul(cfg.alpha_gain, phi_center);
        a_vsv  = sat_mul(cfg.volume_scale, cell_volume);
        a_cc   = sat_mul(phi_center, phi_center);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_c_reg    <= phi_center;
            s1_n_reg    <= phi_north;
            s1_s_reg    <= phi_south;
            s1_ov_reg   <= overlap_sum;
            s1_vx_reg   <= vel_x;
            s1_vy_reg   <= vel_y;
            s1_t1_reg   <= a_t1.val;
            s1_c2_reg   <= a_c2.val;
            s1_gxd_reg  <= a_gxd.val;
            s1_gyd_reg  <= a_gyd.val;
            s1_pm_reg   <= a_pm.val;
            s1_chh_reg  <= a_chh.val;
            s1_nmot_reg <= a_nmot.val;
            s1_dmu_reg  <= a_dmu.val;
            s1_deps_reg <= a_deps.val;
            s1_ac_reg   <= a_ac.val;
            s1_vsv_reg  <= a_vsv.val;
            s1_cc_reg   <= a_cc.val;
            s1_flag_reg <= a_t1.ovf | a_c2.ovf | a_gxd.ovf | a_gyd.ovf | a_pm.ovf
                         | a_chh.ovf | a_nmot.ovf | a_dmu.ovf | a_deps.ovf
                         | a_ac.ovf | a_vsv.ovf | a_cc.ovf;
        end
    end

    // ---- stage 2
    sres_t b_t2, b_c4, b_vxgx, b_vygy, b_m2, b_dmuc, b_depsc, b_vsub, b_xsub;

    word_t s2_c_reg, s2_s_reg, s2_chh_reg, s2_nmot_reg;
    word_t s2_t2_reg, s2_c4_reg, s2_vxgx_reg, s2_vygy_reg, s2_m2_reg;
    word_t s2_dmuc_reg, s2_depsc_reg, s2_vsub_reg, s2_xsub_reg;
    logic  s2_flag_reg;

    always_comb
    begin
        b_t2    = sat_add(s1_t1_reg, s1_n_reg);
        b_c4    = sat_add(s1_c2_reg, s1_c2_reg);
        b_vxgx  = sat_mul(s1_vx_reg, half(s1_gxd_reg));
        b_vygy  = sat_mul(s1_vy_reg, half(s1_gyd_reg));
        b_m2    = sat_mul(s1_ac_reg, s1_pm_reg);
        b_dmuc  = sat_mul(s1_dmu_reg, s1_c_reg);
        b_depsc = sat_mul(s1_deps_reg, s1_c_reg);
        b_vsub  = sat_sub(ONE, s1_vsv_reg);
        b_xsub  = sat_sub(s1_cc_reg, s1_ov_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_c_reg     <= s1_c_reg;
            s2_s_reg     <= s1_s_reg;
            s2_chh_reg   <= s1_chh_reg;
            s2_nmot_reg  <= s1_nmot_reg;
            s2_t2_reg    <= b_t2.val;
            s2_c4_reg    <= b_c4.val;
            s2_vxgx_reg  <= b_vxgx.val;
            s2_vygy_reg  <= b_vygy.val;
            s2_m2_reg    <= b_m2.val;
            s2_dmuc_reg  <= b_dmuc.val;
            s2_depsc_reg <= b_depsc.val;
            s2_vsub_reg  <= b_vsub.val;
            s2_xsub_reg  <= b_xsub.val;
            s2_flag_reg  <= s1_flag_reg | b_t2.ovf | b_c4.ovf | b_vxgx.ovf | b_vygy.ovf
                          | b_m2.ovf | b_dmuc.ovf | b_depsc.ovf | b_vsub.ovf | b_xsub.ovf;
        end
    end

    // ---- stage 3
    sres_t c_t3, c_m3, c_advd, c_volt, c_exct;

    word_t s3_c_reg, s3_c4_reg, s3_nmot_reg;
    word_t s3_t3_reg, s3_m3_reg, s3_advd_reg, s3_volt_reg, s3_exct_reg;
    logic  s3_flag_reg;

    always_comb
    begin
        c_t3   = sat_add(s2_t2_reg, s2_s_reg);
        c_m3   = sat_mul(s2_m2_reg, s2_chh_reg);
        c_advd = sat_sub(s2_vxgx_reg, s2_vygy_reg);
        c_volt = sat_mul(s2_dmuc_reg, s2_vsub_reg);
        c_exct = sat_mul(s2_depsc_reg, s2_xsub_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_c_reg    <= s2_c_reg;
            s3_c4_reg   <= s2_c4_reg;
            s3_nmot_reg <= s2_nmot_reg;
            s3_t3_reg   <= c_t3.val;
            s3_m3_reg   <= c_m3.val;
            s3_advd_reg <= c_advd.val;
            s3_volt_reg <= c_volt.val;
            s3_exct_reg <= c_exct.val;
            s3_flag_reg <= s2_flag_reg | c_t3.ovf | c_m3.ovf | c_advd.ovf
                         | c_volt.ovf | c_exct.ovf;
        end
    end

    // ---- stage 4: laplacian closes, advection weighted
    sres_t d_lap, d_adv;

    word_t s4_c_reg, s4_m3_reg, s4_volt_reg, s4_exct_reg, s4_lap_reg, s4_adv_reg;
    logic  s4_flag_reg;

    always_comb
    begin
        d_lap = sat_sub(s3_t3_reg, s3_c4_reg);
        d_adv = sat_mul(s3_nmot_reg, s3_advd_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s4_c_reg    <= s3_c_reg;
            s4_m3_reg   <= s3_m3_reg;
            s4_volt_reg <= s3_volt_reg;
            s4_exct_reg <= s3_exct_reg;
            s4_lap_reg  <= d_lap.val;
            s4_adv_reg  <= d_adv.val;
            s4_flag_reg <= s3_flag_reg | d_lap.ovf | d_adv.ovf;
        end
    end

    // ---- stage 5
    sres_t e_kl;

    word_t s5_c_reg, s5_m3_reg, s5_volt_reg, s5_exct_reg, s5_adv_reg, s5_kl_reg;
    logic  s5_flag_reg;

    assign e_kl = sat_mul(cfg.kappa_gain, s4_lap_reg);

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s5_c_reg    <= s4_c_reg;
            s5_m3_reg   <= s4_m3_reg;
            s5_volt_reg <= s4_volt_reg;
            s5_exct_reg <= s4_exct_reg;
            s5_adv_reg  <= s4_adv_reg;
            s5_kl_reg   <= e_kl.val;
            s5_flag_reg <= s4_flag_reg | e_kl.ovf;
        end
    end

    // ---- stages 6 to 9: terms summed in a fixed order
    sres_t f_ch, g_s1, h_s2, i_s3;

    word_t s6_c_reg, s6_volt_reg, s6_exct_reg, s6_adv_reg, s6_ch_reg;
    logic  s6_flag_reg;
    word_t s7_c_reg, s7_exct_reg, s7_adv_reg, s7_sum_reg;
    logic  s7_flag_reg;
    word_t s8_c_reg, s8_exct_reg, s8_sum_reg;
    logic  s8_flag_reg;
    word_t s9_c_reg, s9_sum_reg;
    logic  s9_flag_reg;

    assign f_ch = sat_add(s5_kl_reg, s5_m3_reg);
    assign g_s1 = sat_add(s6_ch_reg, s6_volt_reg);
    assign h_s2 = sat_add(s7_sum_reg, s7_adv_reg);
    assign i_s3 = sat_add(s8_sum_reg, s8_exct_reg);

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s6_c_reg    <= s5_c_reg;
            s6_volt_reg <= s5_volt_reg;
            s6_exct_reg <= s5_exct_reg;
            s6_adv_reg  <= s5_adv_reg;
            s6_ch_reg   <= f_ch.val;
            s6_flag_reg <= s5_flag_reg | f_ch.ovf;
        end
        if (en[6])
        begin
            s7_c_reg    <= s6_c_reg;
            s7_exct_reg <= s6_exct_reg;
            s7_adv_reg  <= s6_adv_reg;
            s7_sum_reg  <= g_s1.val;
            s7_flag_reg <= s6_flag_reg | g_s1.ovf;
        end
        if (en[7])
        begin
            s8_c_reg    <= s7_c_reg;
            s8_exct_reg <= s7_exct_reg;
            s8_sum_reg  <= h_s2.val;
            s8_flag_reg <= s7_flag_reg | h_s2.ovf;
        end
        if (en[8])
        begin
            s9_c_reg    <= s8_c_reg;
            s9_sum_reg  <= i_s3.val;
            s9_flag_reg <= s8_flag_reg | i_s3.ovf;
        end
    end

    // ---- stage 10: time step, stage 11: euler update into output register
    sres_t j_p, k_res;

    word_t s10_c_reg, s10_p_reg;
    logic  s10_flag_reg;
    word_t s11_res_reg;
    logic  s11_flag_reg;

    assign j_p   = sat_mul(cfg.step_gain, s9_sum_reg);
    assign k_res = sat_add(s10_c_reg, s10_p_reg);

    always_ff @(posedge clk)
    begin
        if (en[9])
        begin
            s10_c_reg    <= s9_c_reg;
            s10_p_reg    <= j_p.val;
            s10_flag_reg <= s9_flag_reg | j_p.ovf;
        end
        if (en[10])
        begin
            s11_res_reg  <= k_res.val;
            s11_flag_reg <= s10_flag_reg | k_res.ovf;
        end
    end

    assign phi_new   = s11_res_reg;
    assign saturated = s11_flag_reg;

endmodule

// File: src/phase_field_point_update_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// phase_field_point_update_unit
// One explicit Euler step of a cell's phase field at a single grid point.
// ============================================================================
// Usage:
//   point channel  : pt_valid / pt_stall carry the point value, its four
//                    neighbours, cell volume, velocity and overlap sum
//   result channel : res_valid / res_stall carry phi_new and the saturated
//                    flag (set when any step of the update clipped)
//   config channel : cfg_valid / cfg_ready with cfg_index and cfg_data;
//                    cfg_ready is always high, write only while idle
// A word is taken when valid is high and stall is low.
// A point taken shows on res_valid once it reaches the last register stage
// and leaves while res_stall is low. The datapath has eleven register stages,
// each with at most one 32x32 multiply or one saturating add per path, so
// one point enters every cycle while pt_stall is low.
// When res_stall is high the pipe closes up its empty stages and keeps
// taking points until every stage is full; only then pt_stall rises.
// Reset empties the pipe and loads the gains with their default values.
// ============================================================================
module phase_field_point_update_unit
    import pfpu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pt_valid,
    output logic                 pt_stall,
    input  logic [W-1:0]         phi_center,
    input  logic [W-1:0]         phi_east,
    input  logic [W-1:0]         phi_west,
    input  logic [W-1:0]         phi_north,
    input  logic [W-1:0]         phi_south,
    input  logic [W-1:0]         cell_volume,
    input  logic [W-1:0]         vel_x,
    input  logic [W-1:0]         vel_y,
    input  logic [W-1:0]         overlap_sum,
    output logic                 res_valid,
    input  logic                 res_stall,
    output logic [W-1:0]         phi_new,
    output logic                 saturated,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [W-1:0]         cfg_data
);

    cfg_t      cfg;
    pipe_ctl_t ctl;
    word_t     phi_new_w;

    pfpu_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pfpu_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pt_valid  (pt_valid),
        .pt_stall  (pt_stall),
        .res_stall (res_stall),
        .ctl       (ctl)
    );

    pfpu_datapath u_dp (
        .clk         (clk),
        .en          (ctl.en),
        .cfg         (cfg),
        .phi_center  (word_t'(phi_center)),
        .phi_east    (word_t'(phi_east)),
        .phi_west    (word_t'(phi_west)),
        .phi_north   (word_t'(phi_north)),
        .phi_south   (word_t'(phi_south)),
        .cell_volume (word_t'(cell_volume)),
        .vel_x       (word_t'(vel_x)),
        .vel_y       (word_t'(vel_y)),
        .overlap_sum (word_t'(overlap_sum)),
        .phi_new     (phi_new_w),
        .saturated   (saturated)
    );

    assign phi_new   = phi_new_w;
    assign res_valid = ctl.out_valid;

endmodule

// File: src/pfpu_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// pfpu_checker
// Port-level checks on the point update unit, bound to the top level.
// ============================================================================
module pfpu_checker
    import pfpu_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         pt_valid,
    input logic         pt_stall,
    input logic         res_valid,
    input logic         res_stall,
    input logic [W-1:0] phi_new,
    input logic         saturated
);

    // shift register of past res_stall values, newest in bit 0, all ones after reset
    logic [NSTAGE-1:0] stall_hist_reg;
    logic [NSTAGE-1:0] stall_hist_next;

    assign stall_hist_next = {stall_hist_reg[NSTAGE-2:0], res_stall};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_hist_reg <= '1;
        end
        else
        begin
            stall_hist_reg <= stall_hist_next;
        end
    end

    // the input may only back up once a finished word is held at the output
    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        pt_stall |-> (res_valid && res_stall)
    ) else $error("point channel stalled while result side is free");

    // a word taken with no stall since comes out after the pipe length
    a_latency: assert property (
        @(posedge clk) disable iff (!rst_n)
        ($past(pt_valid && !pt_stall, NSTAGE) && (stall_hist_reg == '0)) |-> res_valid
    ) else $error("accepted point did not reach the output in time");

    a_res_valid_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> res_valid
    ) else $error("result word dropped while stalled");

    a_res_data_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> ($stable(phi_new) && $stable(saturated))
    ) else $error("result word changed while stalled");

endmodule

bind phase_field_point_update_unit pfpu_checker u_pfpu_checker (.*);

// File: tb/tb_phase_field_point_update_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_phase_field_point_update_unit
// Self-checking bench for the phase field point update unit. Points are sent
// through the valid/stall channel and each one is scored against a Q16.16
// saturating predictor of the Euler update. Directed corner points come
// first, then random traffic under several gain sets and idle patterns.
// ============================================================================
module tb_phase_field_point_update_unit
    import pfpu_pkg::*;
();

    localparam int     PIPE_DEPTH = NSTAGE;
    localparam int     WATCHDOG   = 4000;
    localparam longint Q_MAX      = longint'(WMAX);
    localparam longint Q_MIN      = longint'(WMIN);

    typedef struct packed {
        word_t phi_center;
        word_t phi_east;
        word_t phi_west;
        word_t phi_north;
        word_t phi_south;
        word_t cell_volume;
        word_t vel_x;
        word_t vel_y;
        word_t overlap_sum;
    } point_t;

    typedef struct packed {
        word_t phi_new;
        logic  saturated;
    } update_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 pt_valid    = 1'b0;
    logic                 pt_stall;
    word_t                phi_center  = '0;
    word_t                phi_east    = '0;
    word_t                phi_west    = '0;
    word_t                phi_north   = '0;
    word_t                phi_south   = '0;
    word_t                cell_volume = '0;
    word_t                vel_x       = '0;
    word_t                vel_y       = '0;
    word_t                overlap_sum = '0;
    logic                 res_valid;
    logic                 res_stall   = 1'b0;
    logic [W-1:0]         phi_new;
    logic                 saturated;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [W-1:0]         cfg_data    = '0;

    cfg_t    gains;
    update_t expected_updates[$];
    int      fail_count     = 0;
    int      gap_pct        = 0;
    int      stall_pct      = 0;
    int      quiet_cycles   = 0;
    bit      clip_hit;

    phase_field_point_update_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pt_valid    (pt_valid),
        .pt_stall    (pt_stall),
        .phi_center  (phi_center),
        .phi_east    (phi_east),
        .phi_west    (phi_west),
        .phi_north   (phi_north),
        .phi_south   (phi_south),
        .cell_volume (cell_volume),
        .vel_x       (vel_x),
        .vel_y       (vel_y),
        .overlap_sum (overlap_sum),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .phi_new     (phi_new),
        .saturated   (saturated),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // saturating Q16.16 arithmetic of the update
    // ------------------------------------------------------------------
    function automatic word_t q_clip(longint v);
        if (v > Q_MAX)
        begin
            clip_hit = 1'b1;
            return word_t'(Q_MAX);
        end
        if (v < Q_MIN)
        begin
            clip_hit = 1'b1;
            return word_t'(Q_MIN);
        end
        return word_t'(v);
    endfunction

    function automatic word_t q_add(word_t a, word_t b);
        return q_clip(longint'(a) + longint'(b));
    endfunction

    function automatic word_t q_sub(word_t a, word_t b);
        return q_clip(longint'(a) - longint'(b));
    endfunction

    // exact product floored by the fraction bits
    function automatic word_t q_mul(word_t a, word_t b);
        longint prod;
        prod = longint'(a) * longint'(b);
        return q_clip(prod >>> FRAC);
    endfunction

    function automatic word_t q_floor_half(word_t a);
        return word_t'(longint'(a) >>> 1);
    endfunction

    function automatic update_t predict_update(point_t p, cfg_t g);
        word_t   c;
        word_t   lap;
        word_t   well;
        word_t   ch;
        word_t   gx;
        word_t   gy;
        word_t   adv;
        word_t   vol;
        word_t   excl;
        word_t   total;
        update_t r;
        c        = p.phi_center;
        clip_hit = 1'b0;
        lap  = q_sub(q_add(q_add(q_add(p.phi_east, p.phi_west), p.phi_north), p.phi_south),
                     q_add(q_add(c, c), q_add(c, c)));
        well = q_mul(q_mul(g.alpha_gain, c), q_sub(g.phase_level, c));
        ch   = q_add(q_mul(g.kappa_gain, lap),
                     q_mul(well, q_sub(c, q_floor_half(g.phase_level))));
        gx   = q_floor_half(q_sub(p.phi_east, p.phi_west));
        gy   = q_floor_half(q_sub(p.phi_north, p.phi_south));
        adv  = q_mul(q_sub(WZERO, g.motility_gain),
                     q_sub(q_mul(p.vel_x, gx), q_mul(p.vel_y, gy)));
        vol  = q_mul(q_mul(q_add(g.volume_gain, g.volume_gain), c),
                     q_sub(ONE, q_mul(g.volume_scale, p.cell_volume)));
        excl = q_mul(q_mul(q_add(g.exclusion_gain, g.exclusion_gain), c),
                     q_sub(q_mul(c, c), p.overlap_sum));
        total = q_add(q_add(q_add(ch, vol), adv), excl);
        r.phi_new   = q_add(c, q_mul(g.step_gain, total));
        r.saturated = clip_hit;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic word_t rand_span(int unsigned span);
        int v;
        v = int'($urandom_range(0, 2 * span)) - int'(span);
        return word_t'(v);
    endfunction

    function automatic word_t gain_of(cfg_t g, cfg_idx_t idx);
        case (idx)
            REG_STEP_GAIN:      return g.step_gain;
            REG_KAPPA_GAIN:     return g.kappa_gain;
            REG_ALPHA_GAIN:     return g.alpha_gain;
            REG_PHASE_LEVEL:    return g.phase_level;
            REG_MOTILITY_GAIN:  return g.motility_gain;
            REG_VOLUME_GAIN:    return g.volume_gain;
            REG_VOLUME_SCALE:   return g.volume_scale;
            default:            return g.exclusion_gain;
        endcase
    endfunction

    function automatic cfg_t uniform_gains(word_t v);
        cfg_t g;
        g.step_gain      = v;
        g.kappa_gain     = v;
        g.alpha_gain     = v;
        g.phase_level    = v;
        g.motility_gain  = v;
        g.volume_gain    = v;
        g.volume_scale   = v;
        g.exclusion_gain = v;
        return g;
    endfunction

    // gains of the size a real simulation uses
    function automatic cfg_t plausible_gains();
        cfg_t g;
        g.step_gain      = rand_span(1 << 11);
        g.kappa_gain     = rand_span(1 << 17);
        g.alpha_gain     = rand_span(1 << 17);
        g.phase_level    = ONE + rand_span(1 << 14);
        g.motility_gain  = rand_span(1 << 17);
        g.volume_gain    = rand_span(1 << 14);
        g.volume_scale   = RST_VOLUME_SCALE + rand_span(1 << 12);
        g.exclusion_gain = rand_span(1 << 17);
        return g;
    endfunction

    function automatic cfg_t wide_gains();
        cfg_t g;
        g = {$urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom};
        return g;
    endfunction

    function automatic point_t make_point(word_t c, word_t e, word_t w, word_t n,
                                          word_t s, word_t volume, word_t vx,
                                          word_t vy, word_t overlap);
        point_t p;
        p.phi_center  = c;
        p.phi_east    = e;
        p.phi_west    = w;
        p.phi_north   = n;
        p.phi_south   = s;
        p.cell_volume = volume;
        p.vel_x       = vx;
        p.vel_y       = vy;
        p.overlap_sum = overlap;
        return p;
    endfunction

    // mostly smooth fields near the bulk value, some noise words mixed in
    function automatic point_t rand_point();
        point_t p;
        word_t  c;
        int     pick;
        int     noisy;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            p = {$urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom};
            return p;
        end
        c = rand_span(1 << 17);
        p = make_point(c, c + rand_span(1 << 14), c + rand_span(1 << 14),
                       c + rand_span(1 << 14), c + rand_span(1 << 14),
                       word_t'($urandom_range(0, 1 << 19)), rand_span(1 << 17),
                       rand_span(1 << 17), word_t'($urandom_range(0, 1 << 18)));
        if (pick < 25)
        begin
            noisy = $urandom_range(0, 8);
            case (noisy)
                0:       p.phi_center  = $urandom;
                1:       p.phi_east    = $urandom;
                2:       p.phi_west    = $urandom;
                3:       p.phi_north   = $urandom;
                4:       p.phi_south   = $urandom;
                5:       p.cell_volume = $urandom;
                6:       p.vel_x       = $urandom;
                7:       p.vel_y       = $urandom;
                default: p.overlap_sum = $urandom;
            endcase
        end
        return p;
    endfunction

    // ------------------------------------------------------------------
    // channel tasks, all entered just after a rising edge
    // ------------------------------------------------------------------
    task automatic send_point(point_t p);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            pt_valid <= 1'b0;
            @(posedge clk);
        end
        pt_valid    <= 1'b1;
        phi_center  <= p.phi_center;
        phi_east    <= p.phi_east;
        phi_west    <= p.phi_west;
        phi_north   <= p.phi_north;
        phi_south   <= p.phi_south;
        cell_volume <= p.cell_volume;
        vel_x       <= p.vel_x;
        vel_y       <= p.vel_y;
        overlap_sum <= p.overlap_sum;
        do
            @(posedge clk);
        while (pt_stall);
        expected_updates.push_back(predict_update(p, gains));
    endtask

    task automatic wait_drained();
        pt_valid <= 1'b0;
        while (expected_updates.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    // all eight registers in index order, block idle
    task automatic load_gains(cfg_t g);
        cfg_idx_t idx;
        for (int k = 0; k < 8; k++)
        begin
            idx = cfg_idx_t'(k);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= gain_of(g, idx);
            do
                @(posedge clk);
            while (!cfg_ready);
            case (idx)
                REG_STEP_GAIN:      gains.step_gain      = g.step_gain;
                REG_KAPPA_GAIN:     gains.kappa_gain     = g.kappa_gain;
                REG_ALPHA_GAIN:     gains.alpha_gain     = g.alpha_gain;
                REG_PHASE_LEVEL:    gains.phase_level    = g.phase_level;
                REG_MOTILITY_GAIN:  gains.motility_gain  = g.motility_gain;
                REG_VOLUME_GAIN:    gains.volume_gain    = g.volume_gain;
                REG_VOLUME_SCALE:   gains.volume_scale   = g.volume_scale;
                default:            gains.exclusion_gain = g.exclusion_gain;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_gains();
        send_point(make_point(ONE, ONE, ONE, ONE, ONE, word_t'(3 * ONE), WZERO, WZERO, ONE));
        send_point(make_point(ONE >>> 1, ONE, WZERO, WZERO, ONE, ONE, ONE, ONE, WZERO));
        send_point(make_point(WMAX, WMIN, WMAX, WMIN, WMAX, WMAX, WMIN, WMAX, WMIN));
        wait_drained();
    endtask

    task automatic test_corner_points();
        load_gains(uniform_gains(ONE));
        send_point(make_point('0, '0, '0, '0, '0, '0, '0, '0, '0));
        send_point(make_point(WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX));
        send_point(make_point(WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN));
        // bulk phase, no forces
        send_point(make_point(ONE, ONE, ONE, ONE, ONE, ONE, WZERO, WZERO, ONE));
        // centre at half the bulk value, double-well zero crossing
        send_point(make_point(ONE >>> 1, '0, '0, '0, '0, '0, '0, '0, '0));
        // smallest negative words: floor rounding of products and halves
        send_point(make_point(-32'sd1, -32'sd1, '0, '0, 32'sd1, -32'sd1, -32'sd1, 32'sd1, -32'sd1));
        send_point(make_point(-32'sd7, -32'sd3, '0, 32'sd5, '0, 32'sd3, -32'sd3, -32'sd5, 32'sd1));
        // gradient subtraction clips high, velocity product clips high
        send_point(make_point(ONE, WMAX, WMIN, '0, '0, ONE, WMAX, '0, '0));
        // velocity product clips low
        send_point(make_point(ONE, WMAX, WMIN, WMIN, WMAX, ONE, WMIN, WMIN, '0));
        send_point(make_point(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                              32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                              32'shAAAA_AAAA, 32'sh5555_5555));
        send_point(make_point(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                              32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                              32'sh5555_5555, 32'shAAAA_AAAA));
        // small negative fraction at the centre
        send_point(make_point(-32'sh8000, -32'sh4000, -32'sh9001, 32'sh0001, -32'sh0003,
                              32'sh4_0000, 32'sh1_8000, -32'sh2_4001, 32'sh0_4000));
        // neighbour sum overflows before the centre is taken off
        send_point(make_point(WMIN, WMAX, WMAX, WMAX, WMAX, '0, '0, '0, '0));
        wait_drained();
    endtask

    task automatic test_gain_extremes();
        load_gains(uniform_gains(WMAX));
        send_point(make_point(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE));
        send_point(make_point(-32'sd1, '0, '0, '0, '0, '0, '0, '0, '0));
        wait_drained();
        load_gains(uniform_gains(WMIN));
        send_point(make_point(ONE, '0, ONE, '0, ONE, ONE, -ONE, ONE, '0));
        send_point(make_point(32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1,
                              32'sd1));
        wait_drained();
        // all gains zero: the point passes through unchanged
        load_gains(uniform_gains(WZERO));
        send_point(make_point(32'sh1234_5678, WMAX, WMIN, WMAX, WMIN, WMAX, WMAX, WMIN, WMIN));
        wait_drained();
    endtask

    task automatic test_random_traffic(int sender_gap, int receiver_stall, int count,
                                       bit full_range);
        if (full_range)
            load_gains(wide_gains());
        else
            load_gains(plausible_gains());
        gap_pct   = sender_gap;
        stall_pct = receiver_stall;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
                wait_drained();
            send_point(rand_point());
        end
        wait_drained();
        gap_pct   = 0;
        stall_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // receiver, scoreboard and watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
            res_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        update_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_updates.size() == 0)
            begin
                $error("unexpected result word: phi_new %h saturated %b", phi_new, saturated);
                fail_count++;
            end
            else
            begin
                want = expected_updates.pop_front();
                if (phi_new !== want.phi_new)
                begin
                    $error("phi_new mismatch: expected %h, actual %h", want.phi_new, phi_new);
                    fail_count++;
                end
                if (saturated !== want.saturated)
                begin
                    $error("saturated mismatch: expected %b, actual %b",
                           want.saturated, saturated);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pt_valid && !pt_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        gains.step_gain      = RST_STEP_GAIN;
        gains.kappa_gain     = RST_KAPPA_GAIN;
        gains.alpha_gain     = RST_ALPHA_GAIN;
        gains.phase_level    = RST_PHASE_LEVEL;
        gains.motility_gain  = RST_MOTILITY_GAIN;
        gains.volume_gain    = RST_VOLUME_GAIN;
        gains.volume_scale   = RST_VOLUME_SCALE;
        gains.exclusion_gain = RST_EXCLUSION_GAIN;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_gains();
        test_corner_points();
        test_gain_extremes();
        test_random_traffic(0, 0, 290, 1'b0);
        test_random_traffic(55, 0, 290, 1'b0);
        test_random_traffic(0, 55, 280, 1'b1);
        test_random_traffic(33, 33, 290, 1'b0);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
